// ===== rtl/ptw_pkg.sv =====
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int TABLE_FRAMES      = 16;
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W = $clog2(TABLE_FRAMES);
    localparam int CNT_W   = $clog2(TABLE_FRAMES + 1);
    localparam int ADDR_W  = FRAME_W + IDX_W;
    localparam int DEPTH   = TABLE_FRAMES * ENTRIES_PER_TABLE;

    localparam int VA_W     = 48;
    localparam int ENTRY_W  = 52;
    localparam int FLAGS_W  = 12;
    localparam int STATUS_W = 2;
    localparam int FIU_W    = 5;
    localparam int LINK_W   = ENTRY_W - FLAGS_W;

    localparam logic [1:0] LEVEL_LEAF = 2'd3;

    localparam logic MODE_MAP   = 1'b0;
    localparam logic MODE_XLATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAMES  = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic issue;
        logic eval;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_end;
    } t_sts;

endpackage

// ===== rtl/ptw_ctrl.sv =====
`timescale 1ns / 1ps

module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.walk_end ? S_DONE : S_ISSUE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_accept_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_ISSUE))
        else $error("accepted item did not start a walk");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_in_ready && !o_cmd.issue && !o_cmd.eval))
        else $error("walk activity during clearing pass");

    a_eval_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |-> $past(o_cmd.issue))
        else $error("evaluation without a preceding table read");
`endif

endmodule

// ===== rtl/ptw_dp.sv =====
`timescale 1ns / 1ps

module ptw_dp
    import ptw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_mode,
    input  logic [VA_W-1:0]     i_virtual_address,
    input  logic [ENTRY_W-1:0]  i_physical_address,
    input  logic [FLAGS_W-1:0]  i_page_flags,
    output logic [STATUS_W-1:0] o_status,
    output logic [ENTRY_W-1:0]  o_translated_address,
    output logic [FIU_W-1:0]    o_frames_in_use
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    logic                r_mode;
    logic [VA_W-1:0]     r_va;
    logic [ENTRY_W-1:0]  r_pa;
    logic [FLAGS_W-1:0]  r_flags;
    logic [1:0]          r_level;
    logic [FRAME_W-1:0]  r_frame;
    logic [CNT_W-1:0]    r_alloc;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ENTRY_W-1:0]  r_rdata;
    logic [STATUS_W-1:0] r_res_status;
    logic [ENTRY_W-1:0]  r_res_addr;
    logic [STATUS_W-1:0] r_o_status;
    logic [ENTRY_W-1:0]  r_o_addr;
    logic [CNT_W-1:0]    r_o_frames;

    logic [IDX_W-1:0]    idx;
    logic [ADDR_W-1:0]   walk_addr;
    logic                entry_zero;
    logic [LINK_W-1:0]   next_link;
    logic                link_bad;
    logic                frames_full;
    logic [FRAME_W-1:0]  new_frame;
    logic                walk_end;
    logic                walk_wr;
    logic                alloc_inc;
    logic [ENTRY_W-1:0]  walk_wdata;
    logic [FRAME_W-1:0]  n_frame;
    logic [STATUS_W-1:0] res_status;
    logic [ENTRY_W-1:0]  res_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;

    always_comb begin
        case (r_level)
            2'd0:    idx = r_va[47:39];
            2'd1:    idx = r_va[38:30];
            2'd2:    idx = r_va[29:21];
            default: idx = r_va[20:12];
        endcase
    end

    assign walk_addr   = {r_frame, idx};
    assign entry_zero  = (r_rdata == '0);
    assign next_link   = r_rdata[ENTRY_W-1:FLAGS_W];
    assign link_bad    = (next_link >= LINK_W'(TABLE_FRAMES));
    assign frames_full = (r_alloc >= CNT_W'(TABLE_FRAMES));
    assign new_frame   = r_alloc[FRAME_W-1:0];

    always_comb begin
        walk_end   = 1'b0;
        walk_wr    = 1'b0;
        alloc_inc  = 1'b0;
        walk_wdata = ENTRY_W'({new_frame, r_flags});
        n_frame    = r_frame;
        res_status = ST_OK;
        res_addr   = '0;
        if (r_level != LEVEL_LEAF) begin
            if (entry_zero) begin
                if (r_mode == MODE_XLATE) begin
                    walk_end   = 1'b1;
                    res_status = ST_NOT_MAPPED;
                end else if (frames_full) begin
                    walk_end   = 1'b1;
                    res_status = ST_NO_FRAMES;
                end else begin
                    walk_wr   = 1'b1;
                    alloc_inc = 1'b1;
                    n_frame   = new_frame;
                end
            end else if (link_bad) begin
                walk_end   = 1'b1;
                res_status = (r_mode == MODE_XLATE) ? ST_NOT_MAPPED : ST_NO_FRAMES;
            end else begin
                n_frame = next_link[FRAME_W-1:0];
            end
        end else begin
            walk_end = 1'b1;
            if (r_mode == MODE_MAP) begin
                walk_wr    = 1'b1;
                walk_wdata = r_pa | ENTRY_W'(r_flags);
            end else if (entry_zero) begin
                res_status = ST_NOT_MAPPED;
            end else begin
                res_addr = {next_link, {FLAGS_W{1'b0}}};
            end
        end
    end

    assign mem_we    = i_cmd.clr || (i_cmd.eval && walk_wr);
    assign mem_waddr = i_cmd.clr ? r_clr_addr : walk_addr;
    assign mem_wdata = i_cmd.clr ? '0 : walk_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.issue) begin
            r_rdata <= r_mem[walk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc    <= CNT_W'(1);
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.eval && alloc_inc) begin
                r_alloc <= r_alloc + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_va    <= i_virtual_address;
            r_pa    <= i_physical_address;
            r_flags <= i_page_flags;
            r_level <= '0;
            r_frame <= '0;
        end
        if (i_cmd.eval) begin
            r_level      <= r_level + 2'd1;
            r_frame      <= n_frame;
            r_res_status <= res_status;
            r_res_addr   <= res_addr;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_addr   <= r_res_addr;
            r_o_frames <= r_alloc;
        end
    end

    assign o_sts.clr_last       = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.walk_end       = walk_end;
    assign o_status             = r_o_status;
    assign o_translated_address = r_o_addr;
    assign o_frames_in_use      = FIU_W'(r_o_frames);

endmodule

// ===== rtl/four_level_page_table_map_walk.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// input    | i_in_valid / o_in_ready   | i_mode, i_virtual_address, i_physical_address,
//          |                           | i_page_flags
// output   | o_out_valid / i_out_ready | o_status, o_translated_address, o_frames_in_use
//
// A full walk accepts the beat, then does a registered table read and its evaluation
// for each of the four levels, and then loads the result register; a walk that stops
// early is shorter.
// After reset a clearing pass zeroes all TABLE_FRAMES * 512 (8192) entries of the table
// store, and no input beat is accepted until it ends.
// The result register lets the next beat enter while a result waits; a finished walk
// holds until the previous result is taken.

module four_level_page_table_map_walk
    import ptw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [VA_W-1:0]     i_virtual_address,
    input  logic [ENTRY_W-1:0]  i_physical_address,
    input  logic [FLAGS_W-1:0]  i_page_flags,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ENTRY_W-1:0]  o_translated_address,
    output logic [FIU_W-1:0]    o_frames_in_use
);

    t_cmd cmd;
    t_sts sts;

    ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ptw_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_mode               (i_mode),
        .i_virtual_address    (i_virtual_address),
        .i_physical_address   (i_physical_address),
        .i_page_flags         (i_page_flags),
        .o_status             (o_status),
        .o_translated_address (o_translated_address),
        .o_frames_in_use      (o_frames_in_use)
    );

endmodule
